// ----- sv/wres_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Weighted random entry select package
// Field widths, action codes, parameter defaults and the command and status
// groups shared by the controller and the datapath.
// -----------------------------------------------------------------------------
package wres_pkg;

   localparam int SLOT_COUNT_DEF  = 16;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int RANDOM_BITS_DEF = 32;

   localparam int INDEX_BITS     = 4;
   localparam int IN_WEIGHT_BITS = 16;
   localparam int IN_RANDOM_BITS = 32;
   localparam int TOTAL_OUT_BITS = 20;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SELECT = 1'b1;

   typedef struct packed {
      logic write;
      logic load;
      logic read;
      logic scan;
      logic mul_init;
      logic mul_step;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic slot_last;
      logic mul_last;
   } status_type;

endpackage

// ----- sv/wres_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Weighted random entry select channels
// Valid/ready channels for request beats and response beats.
// -----------------------------------------------------------------------------
interface wres_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic [wres_pkg::INDEX_BITS-1:0]      slot_index;
   logic [wres_pkg::IN_WEIGHT_BITS-1:0]  slot_weight;
   logic                                 slot_needs_desktop;
   logic                                 desktop_connected;
   logic                                 exclude_valid;
   logic [wres_pkg::INDEX_BITS-1:0]      exclude_slot;
   logic [wres_pkg::IN_RANDOM_BITS-1:0]  random_word;

   modport source (
      output valid, action, slot_index, slot_weight, slot_needs_desktop,
             desktop_connected, exclude_valid, exclude_slot, random_word,
      input  ready
   );
   modport sink (
      input  valid, action, slot_index, slot_weight, slot_needs_desktop,
             desktop_connected, exclude_valid, exclude_slot, random_word,
      output ready
   );
endinterface

interface wres_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 found;
   logic [wres_pkg::INDEX_BITS-1:0]      chosen_slot;
   logic [wres_pkg::TOTAL_OUT_BITS-1:0]  weight_total;

   modport source (
      output valid, found, chosen_slot, weight_total,
      input  ready
   );
   modport sink (
      input  valid, found, chosen_slot, weight_total,
      output ready
   );
endinterface

// ----- sv/wres_ctrl.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Weighted random entry select controller
// Sequences the sum pass, the serial multiply, the scan pass and the
// response register for each select beat.
// -----------------------------------------------------------------------------
module wres_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output wres_pkg::cmd_type    cmd,
   input  wres_pkg::status_type status
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_SUM       = 8'b0000_0010,
      ST_SUM_END   = 8'b0000_0100,
      ST_MUL_SETUP = 8'b0000_1000,
      ST_MUL       = 8'b0001_0000,
      ST_SCAN      = 8'b0010_0000,
      ST_SCAN_END  = 8'b0100_0000,
      ST_RESULT    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == wres_pkg::ACTION_SELECT) begin
                  cmd.load = 1'b1;
                  state_in = ST_SUM;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SUM: begin
            cmd.read = 1'b1;
            if (status.slot_last) begin
               state_in = ST_SUM_END;
            end
         end
         ST_SUM_END: begin
            state_in = ST_MUL_SETUP;
         end
         ST_MUL_SETUP: begin
            cmd.mul_init = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            cmd.scan = 1'b1;
            if (status.slot_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.capture || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_select_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == wres_pkg::ACTION_SELECT) |=> !req_ready)
      else $error("A select beat did not close the input channel.");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("A response beat appeared outside the result state.");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("A stalled response beat was dropped.");

endmodule

// ----- sv/wres_dpath.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Weighted random entry select datapath
// Holds the slot table, sums eligible weights, scales the random word with a
// serial shift-add multiplier and scans for the selected slot.
// -----------------------------------------------------------------------------
module wres_dpath #(
   parameter int SLOT_COUNT  = wres_pkg::SLOT_COUNT_DEF,
   parameter int WEIGHT_BITS = wres_pkg::WEIGHT_BITS_DEF,
   parameter int RANDOM_BITS = wres_pkg::RANDOM_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wres_pkg::cmd_type                    cmd,
   output wres_pkg::status_type                 status,
   input  logic [wres_pkg::INDEX_BITS-1:0]      req_slot_index,
   input  logic [wres_pkg::IN_WEIGHT_BITS-1:0]  req_slot_weight,
   input  logic                                 req_slot_needs_desktop,
   input  logic                                 req_desktop_connected,
   input  logic                                 req_exclude_valid,
   input  logic [wres_pkg::INDEX_BITS-1:0]      req_exclude_slot,
   input  logic [wres_pkg::IN_RANDOM_BITS-1:0]  req_random_word,
   output logic                                 rsp_found,
   output logic [wres_pkg::INDEX_BITS-1:0]      rsp_chosen_slot,
   output logic [wres_pkg::TOTAL_OUT_BITS-1:0]  rsp_weight_total
);

   localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
   localparam int TOTAL_BITS = WEIGHT_BITS + SLOT_BITS;
   localparam int MULT_BITS  = TOTAL_BITS + 1;
   localparam int MCNT_BITS  = $clog2(RANDOM_BITS);
   localparam int CMP_BITS   = (SLOT_BITS > wres_pkg::INDEX_BITS) ?
                               SLOT_BITS : wres_pkg::INDEX_BITS;

   logic [WEIGHT_BITS:0]              entry_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]             entry_valid_ff;
   logic                              wr_in_range;
   logic [SLOT_BITS-1:0]              wr_addr;

   logic [WEIGHT_BITS:0]              rd_entry_ff;
   logic                              rd_hit_ff;
   logic [SLOT_BITS-1:0]              rd_idx_ff;
   logic                              data_vld_ff;
   logic                              scan_ff;

   logic [SLOT_BITS-1:0]              slot_cnt_ff;
   logic [MCNT_BITS-1:0]              mul_cnt_ff;

   logic                              desk_ff;
   logic                              excl_valid_ff;
   logic [wres_pkg::INDEX_BITS-1:0]   excl_ff;
   logic [RANDOM_BITS-1:0]            rnd_ff;
   logic [RANDOM_BITS-1:0]            rnd_sh_ff;

   logic [TOTAL_BITS-1:0]             total_ff;
   logic [TOTAL_BITS-1:0]             total_in;
   logic                              any_ff;
   logic [SLOT_BITS-1:0]              first_ff;

   logic [MULT_BITS-1:0]              mplier_ff;
   logic [MULT_BITS-1:0]              hi_ff;
   logic [MULT_BITS-1:0]              hi_in;
   logic [MULT_BITS:0]                mul_sum;

   logic [TOTAL_BITS-1:0]             running_ff;
   logic [TOTAL_BITS-1:0]             running_in;
   logic                              hit_ff;
   logic [SLOT_BITS-1:0]              chosen_ff;

   logic                              found_ff;
   logic [wres_pkg::INDEX_BITS-1:0]   chosen_out_ff;
   logic [wres_pkg::TOTAL_OUT_BITS-1:0] total_out_ff;

   logic [WEIGHT_BITS-1:0]            rd_weight;
   logic                              rd_flag;
   logic                              excluded;
   logic                              eligible;
   logic                              sum_take;
   logic                              scan_take;
   logic                              reach;

   assign wr_in_range = (32'(req_slot_index) < 32'(SLOT_COUNT));
   assign wr_addr     = SLOT_BITS'(req_slot_index);

   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_range) begin
         entry_mem[wr_addr] <= {req_slot_needs_desktop, WEIGHT_BITS'(req_slot_weight)};
      end
      if (cmd.read) begin
         rd_entry_ff <= entry_mem[slot_cnt_ff];
         rd_hit_ff   <= entry_valid_ff[slot_cnt_ff];
         rd_idx_ff   <= slot_cnt_ff;
      end
   end

   assign rd_weight = rd_hit_ff ? rd_entry_ff[WEIGHT_BITS-1:0] : '0;
   assign rd_flag   = rd_hit_ff && rd_entry_ff[WEIGHT_BITS];
   assign excluded  = excl_valid_ff && (CMP_BITS'(rd_idx_ff) == CMP_BITS'(excl_ff));
   assign eligible  = (rd_weight != '0) && !excluded && !(rd_flag && !desk_ff);
   assign sum_take  = data_vld_ff && !scan_ff && eligible;
   assign scan_take = data_vld_ff && scan_ff && eligible && !hit_ff;

   assign total_in   = total_ff + TOTAL_BITS'(rd_weight);
   assign running_in = running_ff + TOTAL_BITS'(rd_weight);
   assign mul_sum    = {1'b0, hi_ff} + (rnd_sh_ff[0] ? {1'b0, mplier_ff} : '0);
   assign hi_in      = mul_sum[MULT_BITS:1];
   assign reach      = ({1'b0, running_in} >= hi_ff);

   assign status.slot_last = (slot_cnt_ff == SLOT_BITS'(SLOT_COUNT - 1));
   assign status.mul_last  = (mul_cnt_ff == MCNT_BITS'(RANDOM_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         data_vld_ff    <= 1'b0;
         scan_ff        <= 1'b0;
         slot_cnt_ff    <= '0;
         mul_cnt_ff     <= '0;
         any_ff         <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         if (cmd.write && wr_in_range) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         data_vld_ff <= cmd.read;
         scan_ff     <= cmd.scan;
         if (cmd.load) begin
            slot_cnt_ff <= '0;
            any_ff      <= 1'b0;
         end else begin
            if (cmd.read) begin
               slot_cnt_ff <= status.slot_last ? '0 : slot_cnt_ff + 1'b1;
            end
            if (sum_take) begin
               any_ff <= 1'b1;
            end
         end
         if (cmd.mul_init) begin
            mul_cnt_ff <= '0;
            hit_ff     <= 1'b0;
         end else begin
            if (cmd.mul_step) begin
               mul_cnt_ff <= status.mul_last ? '0 : mul_cnt_ff + 1'b1;
            end
            if (scan_take && reach) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         desk_ff       <= req_desktop_connected;
         excl_valid_ff <= req_exclude_valid;
         excl_ff       <= req_exclude_slot;
         rnd_ff        <= RANDOM_BITS'(req_random_word);
         total_ff      <= '0;
      end else if (sum_take) begin
         total_ff <= total_in;
         if (!any_ff) begin
            first_ff <= rd_idx_ff;
         end
      end
      if (cmd.mul_init) begin
         hi_ff      <= '0;
         mplier_ff  <= {1'b0, total_ff} + MULT_BITS'(1);
         rnd_sh_ff  <= rnd_ff;
         running_ff <= '0;
      end else if (cmd.mul_step) begin
         hi_ff     <= hi_in;
         rnd_sh_ff <= rnd_sh_ff >> 1;
      end
      if (scan_take) begin
         running_ff <= running_in;
         if (reach) begin
            chosen_ff <= rd_idx_ff;
         end
      end
      if (cmd.capture) begin
         found_ff      <= any_ff;
         chosen_out_ff <= any_ff ?
                          wres_pkg::INDEX_BITS'(hit_ff ? chosen_ff : first_ff) : '0;
         total_out_ff  <= any_ff ? wres_pkg::TOTAL_OUT_BITS'(total_ff) : '0;
      end
   end

   assign rsp_found        = found_ff;
   assign rsp_chosen_slot  = chosen_out_ff;
   assign rsp_weight_total = total_out_ff;

   a_mul_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_step |-> (hi_ff < mplier_ff))
      else $error("Multiplier partial result reached the multiplicand.");

   a_selected_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && any_ff) |-> (hi_ff <= {1'b0, total_ff}))
      else $error("Scaled random value exceeds the weight total.");

   a_scan_hits: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && any_ff) |-> hit_ff)
      else $error("Scan pass ended without reaching the scaled random value.");

endmodule

// ----- sv/weighted_random_entry_select_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Weighted random entry select
// Roulette wheel selection over a table of weighted slots.
// -----------------------------------------------------------------------------
// Request beats on req_chan either load one slot (action write) or ask for a
// selection (action select). A write gives no response beat; a write to a
// slot beyond the table is dropped.
// A select gives exactly one response beat on rsp_chan: found, the chosen
// slot and the sum of the eligible weights. The input channel stays closed
// from the accepted select until its result is captured in the output
// register: one pass over the slot memory to sum the weights, one shift-add
// step per random bit to scale the random word, and a second pass over the
// slot memory to find the selected slot.
// The response sits in an output register. While the receiver stalls, the
// block keeps accepting writes and may start the next select; that select
// waits in its last step until the pending response beat is taken.
// Synchronous reset clears every slot's valid bit, so all slots read as weight
// zero and nothing is eligible until written. It drops any response in flight.
// -----------------------------------------------------------------------------
module weighted_random_entry_select_top #(
   parameter int SLOT_COUNT  = wres_pkg::SLOT_COUNT_DEF,
   parameter int WEIGHT_BITS = wres_pkg::WEIGHT_BITS_DEF,
   parameter int RANDOM_BITS = wres_pkg::RANDOM_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   wres_req_if.sink     req_chan,
   wres_rsp_if.source   rsp_chan
);

   wres_pkg::cmd_type    cmd;
   wres_pkg::status_type status;

   wres_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .cmd        (cmd),
      .status     (status)
   );

   wres_dpath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .WEIGHT_BITS (WEIGHT_BITS),
      .RANDOM_BITS (RANDOM_BITS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_slot_index         (req_chan.slot_index),
      .req_slot_weight        (req_chan.slot_weight),
      .req_slot_needs_desktop (req_chan.slot_needs_desktop),
      .req_desktop_connected  (req_chan.desktop_connected),
      .req_exclude_valid      (req_chan.exclude_valid),
      .req_exclude_slot       (req_chan.exclude_slot),
      .req_random_word        (req_chan.random_word),
      .rsp_found              (rsp_chan.found),
      .rsp_chosen_slot        (rsp_chan.chosen_slot),
      .rsp_weight_total       (rsp_chan.weight_total)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Weighted random entry select testbench
// Loads table slots and requests weighted selections over the request channel.
// Each request beat is applied to a local copy of the slot table. Each select
// predicts the chosen slot and the eligible weight sum, and the prediction is
// compared with the next response beat. Both sides stall at random.
// -----------------------------------------------------------------------------
module tb;

   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic                                action;
      logic [wres_pkg::INDEX_BITS-1:0]     slot_index;
      logic [wres_pkg::IN_WEIGHT_BITS-1:0] slot_weight;
      logic                                slot_needs_desktop;
      logic                                desktop_connected;
      logic                                exclude_valid;
      logic [wres_pkg::INDEX_BITS-1:0]     exclude_slot;
      logic [wres_pkg::IN_RANDOM_BITS-1:0] random_word;
   } req_beat_type;

   typedef struct packed {
      logic                                found;
      logic [wres_pkg::INDEX_BITS-1:0]     chosen_slot;
      logic [wres_pkg::TOTAL_OUT_BITS-1:0] weight_total;
   } pick_type;

   class roulette_scoreboard;
      logic [wres_pkg::WEIGHT_BITS_DEF-1:0] weight_tbl [wres_pkg::SLOT_COUNT_DEF];
      logic                                 desk_tbl [wres_pkg::SLOT_COUNT_DEF];
      pick_type                             expected_picks [$];
      int                                   mismatches;

      function new();
         for (int i = 0; i < wres_pkg::SLOT_COUNT_DEF; i++) begin
            weight_tbl[i] = '0;
            desk_tbl[i] = 1'b0;
         end
         mismatches = 0;
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction

      function bit eligible(int i, req_beat_type b);
         if (weight_tbl[i] == 0) return 1'b0;
         if (b.exclude_valid && i == int'(b.exclude_slot)) return 1'b0;
         if (desk_tbl[i] && !b.desktop_connected) return 1'b0;
         return 1'b1;
      endfunction

      function pick_type predict_pick(req_beat_type b);
         pick_type        p;
         longint unsigned total;
         longint unsigned running;
         longint unsigned target;
         int              first;
         bit              any;
         bit              hit;
         p = '0;
         total = 0;
         running = 0;
         first = 0;
         any = 1'b0;
         hit = 1'b0;
         for (int i = 0; i < wres_pkg::SLOT_COUNT_DEF; i++) begin
            if (eligible(i, b)) begin
               if (!any) first = i;
               any = 1'b1;
               total += weight_tbl[i];
            end
         end
         if (!any) return p;
         target = (longint'(b.random_word[wres_pkg::RANDOM_BITS_DEF-1:0]) * (total + 1))
                  >> wres_pkg::RANDOM_BITS_DEF;
         p.chosen_slot = first[wres_pkg::INDEX_BITS-1:0];
         for (int i = 0; i < wres_pkg::SLOT_COUNT_DEF && !hit; i++) begin
            if (eligible(i, b)) begin
               running += weight_tbl[i];
               if (running >= target) begin
                  p.chosen_slot = i[wres_pkg::INDEX_BITS-1:0];
                  hit = 1'b1;
               end
            end
         end
         p.found = 1'b1;
         p.weight_total = total[wres_pkg::TOTAL_OUT_BITS-1:0];
         return p;
      endfunction

      function void note_request(req_beat_type b);
         if (b.action == wres_pkg::ACTION_WRITE) begin
            if (int'(b.slot_index) < wres_pkg::SLOT_COUNT_DEF) begin
               weight_tbl[b.slot_index] = b.slot_weight[wres_pkg::WEIGHT_BITS_DEF-1:0];
               desk_tbl[b.slot_index] = b.slot_needs_desktop;
            end
         end else begin
            expected_picks.push_back(predict_pick(b));
         end
      endfunction

      function void check_pick(pick_type got);
         pick_type want;
         if (expected_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response beat: found=%0d slot=%0d total=%0d",
                        got.found, got.chosen_slot, got.weight_total);
            return;
         end
         want = expected_picks.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected found=%0d slot=%0d total=%0d,",
                        want.found, want.chosen_slot, want.weight_total,
                        " got found=%0d slot=%0d total=%0d",
                        got.found, got.chosen_slot, got.weight_total);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   sent;
   int   idle_count;

   roulette_scoreboard board = new();

   wres_req_if req_chan();
   wres_rsp_if rsp_chan();

   weighted_random_entry_select_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 13);
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            board.note_request(req_beat_type'{req_chan.action, req_chan.slot_index,
                                              req_chan.slot_weight,
                                              req_chan.slot_needs_desktop,
                                              req_chan.desktop_connected,
                                              req_chan.exclude_valid,
                                              req_chan.exclude_slot,
                                              req_chan.random_word});
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_pick(pick_type'{rsp_chan.found, rsp_chan.chosen_slot,
                                        rsp_chan.weight_total});
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_count <= 0;
         end else if (idle_count >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
         end else begin
            idle_count <= idle_count + 1;
         end
      end
   end

   function automatic req_beat_type make_write(int idx,
                                               logic [wres_pkg::IN_WEIGHT_BITS-1:0] w,
                                               bit nd);
      req_beat_type b;
      b.action = wres_pkg::ACTION_WRITE;
      b.slot_index = idx[wres_pkg::INDEX_BITS-1:0];
      b.slot_weight = w;
      b.slot_needs_desktop = nd;
      b.desktop_connected = 1'($urandom_range(1));
      b.exclude_valid = 1'($urandom_range(1));
      b.exclude_slot = wres_pkg::INDEX_BITS'($urandom_range(15));
      b.random_word = wres_pkg::IN_RANDOM_BITS'($urandom);
      return b;
   endfunction

   function automatic req_beat_type make_select(bit desk, bit ex_valid, int ex,
                                                logic [wres_pkg::IN_RANDOM_BITS-1:0] rnd);
      req_beat_type b;
      b.action = wres_pkg::ACTION_SELECT;
      b.slot_index = wres_pkg::INDEX_BITS'($urandom_range(15));
      b.slot_weight = wres_pkg::IN_WEIGHT_BITS'($urandom);
      b.slot_needs_desktop = 1'($urandom_range(1));
      b.desktop_connected = desk;
      b.exclude_valid = ex_valid;
      b.exclude_slot = ex[wres_pkg::INDEX_BITS-1:0];
      b.random_word = rnd;
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b);
      req_chan.valid              <= 1'b1;
      req_chan.action             <= b.action;
      req_chan.slot_index         <= b.slot_index;
      req_chan.slot_weight        <= b.slot_weight;
      req_chan.slot_needs_desktop <= b.slot_needs_desktop;
      req_chan.desktop_connected  <= b.desktop_connected;
      req_chan.exclude_valid      <= b.exclude_valid;
      req_chan.exclude_slot       <= b.exclude_slot;
      req_chan.random_word        <= b.random_word;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      if (!calm && $urandom_range(99) < 13) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   function automatic logic [wres_pkg::IN_RANDOM_BITS-1:0] pick_random_word();
      int r;
      r = int'($urandom_range(99));
      if (r < 10) return '0;
      if (r < 20) return '1;
      return wres_pkg::IN_RANDOM_BITS'($urandom);
   endfunction

   initial begin
      int  mode;
      int  r;
      bit  drained;
      logic [wres_pkg::IN_WEIGHT_BITS-1:0] w;

      reset = 1'b1;
      calm = 1'b0;
      sent = 0;
      drained = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.action = wres_pkg::ACTION_WRITE;
      req_chan.slot_index = '0;
      req_chan.slot_weight = '0;
      req_chan.slot_needs_desktop = 1'b0;
      req_chan.desktop_connected = 1'b0;
      req_chan.exclude_valid = 1'b0;
      req_chan.exclude_slot = '0;
      req_chan.random_word = '0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // An empty table has nothing eligible.
      send_beat(make_select(1'b1, 1'b0, 0, wres_pkg::IN_RANDOM_BITS'($urandom)));
      send_beat(make_write(0, 16'h0001, 1'b0));
      send_beat(make_write(15, 16'hFFFF, 1'b1));
      send_beat(make_write(7, 16'h8000, 1'b0));
      send_beat(make_select(1'b1, 1'b0, 0, 32'h0000_0000));
      send_beat(make_select(1'b1, 1'b0, 0, 32'hFFFF_FFFF));
      send_beat(make_select(1'b0, 1'b0, 0, 32'hFFFF_FFFF));
      send_beat(make_select(1'b1, 1'b1, 15, 32'hFFFF_FFFF));
      send_beat(make_select(1'b1, 1'b1, 0, 32'h0000_0000));
      // The exclude index is ignored unless its valid bit is set.
      send_beat(make_select(1'b1, 1'b0, 0, 32'h0000_0000));
      send_beat(make_select(1'b1, 1'b1, 9, 32'h8000_0000));
      send_beat(make_write(7, 16'h0000, 1'b1));
      send_beat(make_write(0, 16'h0000, 1'b0));
      send_beat(make_select(1'b0, 1'b0, 0, wres_pkg::IN_RANDOM_BITS'($urandom)));
      send_beat(make_select(1'b1, 1'b1, 15, wres_pkg::IN_RANDOM_BITS'($urandom)));
      send_beat(make_select(1'b1, 1'b0, 0, wres_pkg::IN_RANDOM_BITS'($urandom)));
      send_beat(make_write(3, 16'hFFFF, 1'b0));
      send_beat(make_write(15, 16'h0001, 1'b0));
      send_beat(make_select(1'b0, 1'b0, 0, 32'h0000_0000));
      send_beat(make_select(1'b0, 1'b0, 0, 32'hFFFF_FFFF));
      hold_until_drained();

      while (sent < 540) begin
         calm = (sent >= 250 && sent < 370);
         if (!drained && sent >= 300) begin
            hold_until_drained();
            drained = 1'b1;
         end
         mode = int'($urandom_range(9));
         if (mode == 0) begin
            for (int i = 0; i < wres_pkg::SLOT_COUNT_DEF; i++)
               send_beat(make_write(i, 16'hFFFF, $urandom_range(99) < 10));
         end else begin
            repeat ($urandom_range(0, 5)) begin
               r = int'($urandom_range(99));
               if (r < 15) w = '0;
               else if (r < 50) w = wres_pkg::IN_WEIGHT_BITS'($urandom);
               else w = wres_pkg::IN_WEIGHT_BITS'($urandom_range(1, 300));
               send_beat(make_write(int'($urandom_range(15)), w,
                                    $urandom_range(99) < 30));
            end
         end
         repeat ($urandom_range(1, 4))
            send_beat(make_select(1'($urandom_range(1)), 1'($urandom_range(1)),
                                  int'($urandom_range(15)), pick_random_word()));
      end
      calm = 1'b0;

      hold_until_drained();
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// ----- weighted_random_entry_select_top.f -----
sv/wres_pkg.sv
sv/wres_if.sv
sv/wres_ctrl.sv
sv/wres_dpath.sv
sv/weighted_random_entry_select_top.sv
tb/tb.sv
